[rtl/sdt_pkg.sv]
// ---------------------------------------------------------------------------
// sdt_pkg: shared types and constants for the sorted date table
// Field widths, operation codes, sequencer states and beat layouts.
// ---------------------------------------------------------------------------
package sdt_pkg;

  localparam int FUNC_W   = 3;
  localparam int HANDLE_W = 16;
  localparam int YEAR_W   = 14;
  localparam int DAY_W    = 9;
  localparam int TIME_W   = 37;
  localparam int DATE_W   = YEAR_W + DAY_W;
  localparam int KEY_W    = DATE_W + TIME_W;
  localparam int IDX_W    = 7;
  localparam int DCNT_W   = 7;
  localparam int TCNT_W   = 8;

  localparam int DATED_DEPTH_DEF   = 64;
  localparam int UNDATED_DEPTH_DEF = 64;

  localparam logic [FUNC_W-1:0] FN_INSERT        = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REM_HANDLE    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REM_INDEX     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ_INDEX    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_UNDATED_RANGE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DATE_RANGE    = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INS_RD, ST_INS_EV,
    ST_RHD_RD, ST_RHD_EV,
    ST_RHU_RD, ST_RHU_EV,
    ST_SHD_RD, ST_SHD_EV,
    ST_SHU_RD, ST_SHU_EV,
    ST_RDD, ST_RDD_EV,
    ST_RDU, ST_RDU_EV,
    ST_DR_RD, ST_DR_EV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [HANDLE_W-1:0] handle;
    logic                has_date;
    logic [YEAR_W-1:0]   year;
    logic [DAY_W-1:0]    day_of_year;
    logic [TIME_W-1:0]   time_of_day;
    logic [IDX_W-1:0]    index;
  } req_beat_t;

  typedef struct packed {
    logic                ok;
    logic [HANDLE_W-1:0] handle_out;
    logic [IDX_W-1:0]    first_pos;
    logic [IDX_W-1:0]    last_pos;
    logic [DCNT_W-1:0]   dated_count;
    logic [TCNT_W-1:0]   total_count;
  } rsp_beat_t;

  // compare unit result
  typedef struct packed {
    logic lt;      // stored key below probe key
    logic eq;      // stored key equals probe key
    logic day_eq;  // same year and day
    logic h_eq;    // handles match
  } cmp_res_t;

endpackage

[rtl/sdt_req_if.sv]
// ---------------------------------------------------------------------------
// sdt_req_if: request channel
// Valid/ready channel carrying one command beat.
// ---------------------------------------------------------------------------
interface sdt_req_if;
  logic               valid;
  logic               ready;
  sdt_pkg::req_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/sdt_rsp_if.sv]
// ---------------------------------------------------------------------------
// sdt_rsp_if: response channel
// Valid/ready channel carrying one result beat.
// ---------------------------------------------------------------------------
interface sdt_rsp_if;
  logic               valid;
  logic               ready;
  sdt_pkg::rsp_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/sdt_cmp.sv]
// ---------------------------------------------------------------------------
// sdt_cmp: shared key and handle compare unit
// One magnitude compare on the key, date-field equality, handle equality.
// ---------------------------------------------------------------------------
module sdt_cmp (
  input  logic [sdt_pkg::KEY_W-1:0]    stored_key,
  input  logic [sdt_pkg::KEY_W-1:0]    probe_key,
  input  logic [sdt_pkg::HANDLE_W-1:0] stored_handle,
  input  logic [sdt_pkg::HANDLE_W-1:0] probe_handle,
  output sdt_pkg::cmp_res_t            res
);
  assign res.lt     = stored_key < probe_key;
  assign res.eq     = stored_key == probe_key;
  assign res.day_eq = stored_key[sdt_pkg::KEY_W-1:sdt_pkg::TIME_W]
                   == probe_key[sdt_pkg::KEY_W-1:sdt_pkg::TIME_W];
  assign res.h_eq   = stored_handle == probe_handle;
endmodule

[rtl/sorted_date_table_unit.sv]
// ---------------------------------------------------------------------------
// sorted_date_table_unit: sorted dated list plus undated list
// Undated inserts, ranges of the undated list and bad indexes finish with
//   no list walk; otherwise entries are visited one by one (insert walks
//   down from the tail, removes find the entry then shift, date range
//   scans all). One command at a time; each list has one memory read
//   port, and searches use the shared compare unit. Reset clears the fill
//   counts, the sequencer and the output valid; list contents stay undefined.
// ---------------------------------------------------------------------------
module sorted_date_table_unit #(
  parameter int DATED_DEPTH   = sdt_pkg::DATED_DEPTH_DEF,
  parameter int UNDATED_DEPTH = sdt_pkg::UNDATED_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sdt_req_if.sink    req,
  sdt_rsp_if.source  rsp
);
  localparam int KW  = sdt_pkg::KEY_W;
  localparam int HW  = sdt_pkg::HANDLE_W;
  localparam int IW  = sdt_pkg::IDX_W;
  localparam int DAW = (DATED_DEPTH > 1) ? $clog2(DATED_DEPTH) : 1;
  localparam int UAW = (UNDATED_DEPTH > 1) ? $clog2(UNDATED_DEPTH) : 1;
  localparam int DFW = $clog2(DATED_DEPTH + 1);
  localparam int UFW = $clog2(UNDATED_DEPTH + 1);
  // pointer wide enough for either fill count
  localparam int PW  = (DFW > UFW) ? DFW : UFW;
  // wide enough for totals and for the incoming index
  localparam int CW  = ((PW > IW) ? PW : IW) + 1;

  sdt_pkg::state_t state, state_next;

  // dated keys/handles and undated handles
  logic [KW-1:0] dk_mem [DATED_DEPTH];
  logic [HW-1:0] dh_mem [DATED_DEPTH];
  logic [HW-1:0] uh_mem [UNDATED_DEPTH];
  logic [KW-1:0] dk_rd;
  logic [HW-1:0] dh_rd, uh_rd;
  logic [DAW-1:0] d_raddr, d_waddr;
  logic [UAW-1:0] u_raddr, u_waddr;
  logic           d_we, u_we;
  logic [KW-1:0]  d_wkey;
  logic [HW-1:0]  d_whandle, u_whandle;

  logic [DFW-1:0] dfill, dfill_next;
  logic [UFW-1:0] ufill, ufill_next;
  logic [PW-1:0]  ptr, ptr_next;

  // latched command
  logic [HW-1:0]  h_q;
  logic [KW-1:0]  key_q;

  // result being built
  logic           r_ok, r_ok_next;
  logic [HW-1:0]  r_hout, r_hout_next;
  logic [IW-1:0]  r_first, r_first_next;
  logic [IW-1:0]  r_last, r_last_next;
  logic           found, found_next;

  logic                rsp_valid;
  sdt_pkg::rsp_beat_t  rsp_data;
  logic                out_free;

  sdt_pkg::cmp_res_t cres;
  logic [KW-1:0]     req_key;
  logic [CW-1:0]     idx_w, dfill_w, ufill_w, idx_u;
  logic              idx_in_d, idx_in_u;
  logic [PW:0]       ptr_inc;
  logic              ptr_at_d, ptr_at_u, shd_end, shu_end;
  logic              ins_stop;
  logic              accept;

  assign req.ready = (state == sdt_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;

  assign req_key = {req.data.year, req.data.day_of_year, req.data.time_of_day};
  assign idx_w   = CW'(req.data.index);
  assign dfill_w = CW'(dfill);
  assign ufill_w = CW'(ufill);
  assign idx_u   = idx_w - dfill_w;
  assign idx_in_d = idx_w < dfill_w;
  assign idx_in_u = !idx_in_d && (idx_u < ufill_w);

  assign ptr_inc  = {1'b0, ptr} + (PW+1)'(1);
  assign ptr_at_d = ptr == PW'(dfill);
  assign ptr_at_u = ptr == PW'(ufill);
  assign shd_end  = ptr_inc >= (PW+1)'(dfill);
  assign shu_end  = ptr_inc >= (PW+1)'(ufill);

  // insert slot found: entry below is smaller, or the key ties the tail
  // (a tie with the last key appends)
  assign ins_stop = cres.lt || (ptr_at_d && cres.eq);

  // shared compare unit; handle side picks the list being searched
  sdt_cmp u_cmp (
    .stored_key    (dk_rd),
    .probe_key     (key_q),
    .stored_handle ((state == sdt_pkg::ST_RHU_EV) ? uh_rd : dh_rd),
    .probe_handle  (h_q),
    .res           (cres)
  );

  // read addresses follow the sequencer step
  always_comb begin
    unique case (state)
      sdt_pkg::ST_INS_RD: d_raddr = DAW'(ptr - PW'(1));
      sdt_pkg::ST_SHD_RD: d_raddr = DAW'(ptr_inc);
      default:            d_raddr = DAW'(ptr);
    endcase
    u_raddr = (state == sdt_pkg::ST_SHU_RD) ? UAW'(ptr_inc) : UAW'(ptr);
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dk_mem[d_waddr] <= d_wkey;
      dh_mem[d_waddr] <= d_whandle;
    end
    if (u_we) begin
      uh_mem[u_waddr] <= u_whandle;
    end
    dk_rd <= dk_mem[d_raddr];
    dh_rd <= dh_mem[d_raddr];
    uh_rd <= uh_mem[u_raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sdt_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = sdt_pkg::ST_DONE;
          case (req.data.func)
            sdt_pkg::FN_INSERT: begin
              if (req.data.has_date && dfill != DFW'(DATED_DEPTH))
                state_next = sdt_pkg::ST_INS_RD;
            end
            sdt_pkg::FN_REM_HANDLE: state_next = sdt_pkg::ST_RHD_RD;
            sdt_pkg::FN_REM_INDEX: begin
              if (idx_in_d)      state_next = sdt_pkg::ST_SHD_RD;
              else if (idx_in_u) state_next = sdt_pkg::ST_SHU_RD;
            end
            sdt_pkg::FN_READ_INDEX: begin
              if (idx_in_d)      state_next = sdt_pkg::ST_RDD;
              else if (idx_in_u) state_next = sdt_pkg::ST_RDU;
            end
            sdt_pkg::FN_DATE_RANGE: state_next = sdt_pkg::ST_DR_RD;
            default: state_next = sdt_pkg::ST_DONE;
          endcase
        end
      end
      sdt_pkg::ST_INS_RD:
        state_next = (ptr == '0) ? sdt_pkg::ST_DONE : sdt_pkg::ST_INS_EV;
      sdt_pkg::ST_INS_EV:
        state_next = ins_stop ? sdt_pkg::ST_DONE : sdt_pkg::ST_INS_RD;
      sdt_pkg::ST_RHD_RD:
        state_next = ptr_at_d ? sdt_pkg::ST_RHU_RD : sdt_pkg::ST_RHD_EV;
      sdt_pkg::ST_RHD_EV:
        state_next = cres.h_eq ? sdt_pkg::ST_SHD_RD : sdt_pkg::ST_RHD_RD;
      sdt_pkg::ST_RHU_RD:
        state_next = ptr_at_u ? sdt_pkg::ST_DONE : sdt_pkg::ST_RHU_EV;
      sdt_pkg::ST_RHU_EV:
        state_next = cres.h_eq ? sdt_pkg::ST_SHU_RD : sdt_pkg::ST_RHU_RD;
      sdt_pkg::ST_SHD_RD:
        state_next = shd_end ? sdt_pkg::ST_DONE : sdt_pkg::ST_SHD_EV;
      sdt_pkg::ST_SHD_EV: state_next = sdt_pkg::ST_SHD_RD;
      sdt_pkg::ST_SHU_RD:
        state_next = shu_end ? sdt_pkg::ST_DONE : sdt_pkg::ST_SHU_EV;
      sdt_pkg::ST_SHU_EV: state_next = sdt_pkg::ST_SHU_RD;
      sdt_pkg::ST_RDD:    state_next = sdt_pkg::ST_RDD_EV;
      sdt_pkg::ST_RDD_EV: state_next = sdt_pkg::ST_DONE;
      sdt_pkg::ST_RDU:    state_next = sdt_pkg::ST_RDU_EV;
      sdt_pkg::ST_RDU_EV: state_next = sdt_pkg::ST_DONE;
      sdt_pkg::ST_DR_RD:
        state_next = ptr_at_d ? sdt_pkg::ST_DONE : sdt_pkg::ST_DR_EV;
      sdt_pkg::ST_DR_EV:  state_next = sdt_pkg::ST_DR_RD;
      sdt_pkg::ST_DONE:
        if (out_free) state_next = sdt_pkg::ST_IDLE;
      default: state_next = sdt_pkg::ST_IDLE;
    endcase
  end

  // datapath controls and writes
  always_comb begin
    dfill_next   = dfill;
    ufill_next   = ufill;
    ptr_next     = ptr;
    r_ok_next    = r_ok;
    r_hout_next  = r_hout;
    r_first_next = r_first;
    r_last_next  = r_last;
    found_next   = found;
    d_we      = 1'b0;
    d_waddr   = DAW'(ptr);
    d_wkey    = key_q;
    d_whandle = h_q;
    u_we      = 1'b0;
    u_waddr   = UAW'(ufill);
    u_whandle = req.data.handle;
    unique case (state)
      sdt_pkg::ST_IDLE: begin
        if (accept) begin
          r_ok_next    = 1'b0;
          r_hout_next  = '0;
          r_first_next = '0;
          r_last_next  = '0;
          found_next   = 1'b0;
          ptr_next     = '0;
          case (req.data.func) inside
            sdt_pkg::FN_INSERT: begin
              ptr_next = PW'(dfill);
              if (!req.data.has_date && ufill != UFW'(UNDATED_DEPTH)) begin
                u_we       = 1'b1;
                ufill_next = ufill + UFW'(1);
                r_ok_next  = 1'b1;
              end
            end
            sdt_pkg::FN_REM_INDEX, sdt_pkg::FN_READ_INDEX: begin
              ptr_next = idx_in_d ? PW'(idx_w) : PW'(idx_u);
            end
            sdt_pkg::FN_UNDATED_RANGE: begin
              if (ufill != '0) begin
                r_ok_next    = 1'b1;
                r_first_next = IW'(dfill);
                r_last_next  = IW'(dfill_w + ufill_w - CW'(1));
              end
            end
            default: ptr_next = '0;
          endcase
        end
      end
      sdt_pkg::ST_INS_RD: begin
        // walked past the head: new entry lands at 0
        if (ptr == '0) begin
          d_we       = 1'b1;
          dfill_next = dfill + DFW'(1);
          r_ok_next  = 1'b1;
        end
      end
      sdt_pkg::ST_INS_EV: begin
        d_we = 1'b1;
        if (ins_stop) begin
          dfill_next = dfill + DFW'(1);
          r_ok_next  = 1'b1;
        end else begin
          // move the larger entry up one slot
          d_wkey    = dk_rd;
          d_whandle = dh_rd;
          ptr_next  = ptr - PW'(1);
        end
      end
      sdt_pkg::ST_RHD_RD: if (ptr_at_d) ptr_next = '0;
      sdt_pkg::ST_RHD_EV: if (!cres.h_eq) ptr_next = PW'(ptr_inc);
      sdt_pkg::ST_RHU_EV: if (!cres.h_eq) ptr_next = PW'(ptr_inc);
      sdt_pkg::ST_SHD_RD: begin
        if (shd_end) begin
          dfill_next = dfill - DFW'(1);
          r_ok_next  = 1'b1;
        end
      end
      sdt_pkg::ST_SHD_EV: begin
        d_we      = 1'b1;
        d_wkey    = dk_rd;
        d_whandle = dh_rd;
        ptr_next  = PW'(ptr_inc);
      end
      sdt_pkg::ST_SHU_RD: begin
        if (shu_end) begin
          ufill_next = ufill - UFW'(1);
          r_ok_next  = 1'b1;
        end
      end
      sdt_pkg::ST_SHU_EV: begin
        u_we      = 1'b1;
        u_waddr   = UAW'(ptr);
        u_whandle = uh_rd;
        ptr_next  = PW'(ptr_inc);
      end
      sdt_pkg::ST_RDD_EV: begin
        r_ok_next   = 1'b1;
        r_hout_next = dh_rd;
      end
      sdt_pkg::ST_RDU_EV: begin
        r_ok_next   = 1'b1;
        r_hout_next = uh_rd;
      end
      sdt_pkg::ST_DR_EV: begin
        if (cres.day_eq) begin
          if (!found) r_first_next = IW'(ptr);
          r_last_next = IW'(ptr);
          found_next  = 1'b1;
          r_ok_next   = 1'b1;
        end
        ptr_next = PW'(ptr_inc);
      end
      default: ptr_next = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sdt_pkg::ST_IDLE;
      dfill     <= '0;
      ufill     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      dfill <= dfill_next;
      ufill <= ufill_next;
      if (state == sdt_pkg::ST_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    r_ok    <= r_ok_next;
    r_hout  <= r_hout_next;
    r_first <= r_first_next;
    r_last  <= r_last_next;
    found   <= found_next;
    if (accept) begin
      h_q   <= req.data.handle;
      key_q <= req_key;
    end
    if (state == sdt_pkg::ST_DONE && out_free) begin
      rsp_data.ok          <= r_ok;
      rsp_data.handle_out  <= r_hout;
      rsp_data.first_pos   <= r_first;
      rsp_data.last_pos    <= r_last;
      rsp_data.dated_count <= sdt_pkg::DCNT_W'(dfill);
      rsp_data.total_count <= sdt_pkg::TCNT_W'(dfill_w + ufill_w);
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

endmodule

[dv/tb_sorted_date_table_unit.sv]
// ---------------------------------------------------------------------------
// tb_sorted_date_table_unit: regression bench for the sorted date table
// Drives commands over the request channel, predicts each response with a
// behavioral table model and checks every response field by field.
// ---------------------------------------------------------------------------
module tb_sorted_date_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NDATED   = sdt_pkg::DATED_DEPTH_DEF;
  localparam int NUNDATED = sdt_pkg::UNDATED_DEPTH_DEF;
  localparam int KW       = sdt_pkg::KEY_W;
  localparam int TW       = sdt_pkg::TIME_W;
  localparam int HW       = sdt_pkg::HANDLE_W;
  localparam int IW       = sdt_pkg::IDX_W;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;

  sdt_req_if req ();
  sdt_rsp_if rsp ();

  sorted_date_table_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // Table shadow: dated keys sorted ascending, undated handles in arrival order.
  logic [KW-1:0] tbl_key [$];
  logic [HW-1:0] tbl_dh  [$];
  logic [HW-1:0] tbl_uh  [$];

  sdt_pkg::rsp_beat_t pending_rsp [$];

  int  send_idle_pct;    // sender gap chance, percent
  int  recv_stall_pct;   // receiver stall chance, percent
  int  hold_off_cycles;  // long receiver hold-off request
  int  errors;
  int  n_beats_sent;
  int  n_beats_checked;
  int  n_ok;
  longint cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout watchdog.
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d responses pending",
                 cycle_cnt, pending_rsp.size());
        $display("sorted_date_table_unit regression: fail");
        $finish;
      end
    end
  end

  // Predict the response for one command and update the shadow table.
  function automatic sdt_pkg::rsp_beat_t table_apply(sdt_pkg::req_beat_t c);
    sdt_pkg::rsp_beat_t r;
    logic [KW-1:0]      key;
    int                 pos;
    int                 idx;
    bit                 hit;
    r   = '0;
    key = {c.year, c.day_of_year, c.time_of_day};
    idx = c.index;
    case (c.func) inside
      sdt_pkg::FN_INSERT: begin
        if (c.has_date) begin
          if (tbl_key.size() < NDATED) begin
            pos = tbl_key.size();
            if (pos > 0 && key < tbl_key[pos-1]) begin
              pos = 0;
              while (tbl_key[pos] < key) pos++;
            end
            tbl_key.insert(pos, key);
            tbl_dh.insert(pos, c.handle);
            r.ok = 1'b1;
          end
        end else if (tbl_uh.size() < NUNDATED) begin
          tbl_uh.insert(tbl_uh.size(), c.handle);
          r.ok = 1'b1;
        end
      end
      sdt_pkg::FN_REM_HANDLE: begin
        hit = 1'b0;
        for (int i = 0; i < tbl_dh.size() && !hit; i++)
          if (tbl_dh[i] == c.handle) begin
            tbl_dh.delete(i);
            tbl_key.delete(i);
            hit = 1'b1;
          end
        for (int i = 0; i < tbl_uh.size() && !hit; i++)
          if (tbl_uh[i] == c.handle) begin
            tbl_uh.delete(i);
            hit = 1'b1;
          end
        r.ok = hit;
      end
      sdt_pkg::FN_REM_INDEX, sdt_pkg::FN_READ_INDEX: begin
        if (idx < tbl_dh.size()) begin
          if (c.func == sdt_pkg::FN_REM_INDEX) begin
            tbl_dh.delete(idx);
            tbl_key.delete(idx);
          end else begin
            r.handle_out = tbl_dh[idx];
          end
          r.ok = 1'b1;
        end else if (idx - tbl_dh.size() < tbl_uh.size()) begin
          if (c.func == sdt_pkg::FN_REM_INDEX) tbl_uh.delete(idx - tbl_dh.size());
          else r.handle_out = tbl_uh[idx - tbl_dh.size()];
          r.ok = 1'b1;
        end
      end
      sdt_pkg::FN_UNDATED_RANGE: begin
        if (tbl_uh.size() > 0) begin
          r.ok        = 1'b1;
          r.first_pos = IW'(tbl_dh.size());
          r.last_pos  = IW'(tbl_dh.size() + tbl_uh.size() - 1);
        end
      end
      sdt_pkg::FN_DATE_RANGE: begin
        for (int i = 0; i < tbl_key.size(); i++)
          if (tbl_key[i][KW-1:TW] == key[KW-1:TW]) begin
            if (!r.ok) r.first_pos = IW'(i);
            r.last_pos = IW'(i);
            r.ok       = 1'b1;
          end
      end
      default: ;
    endcase
    r.dated_count = sdt_pkg::DCNT_W'(tbl_dh.size());
    r.total_count = sdt_pkg::TCNT_W'(tbl_dh.size() + tbl_uh.size());
    return r;
  endfunction

  // Send one command beat; prediction is made when the beat is accepted.
  // Called at a falling edge; valid stays up until the next call or a park.
  task automatic send_cmd(sdt_pkg::req_beat_t c);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.data  <= c;
    do @(posedge clk); while (!req.ready);
    pending_rsp.insert(pending_rsp.size(), table_apply(c));
    n_beats_sent++;
    @(negedge clk);
  endtask

  // Response side: random stalls plus an optional long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      rsp.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Response checker.
  always @(posedge clk) begin
    sdt_pkg::rsp_beat_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response %p", $time, rsp.data);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        n_beats_checked++;
        if (rsp.data.ok) n_ok++;
        if (rsp.data.ok !== want.ok)
          $display("%0t: ok exp %0d got %0d", $time, want.ok, rsp.data.ok);
        if (rsp.data.handle_out !== want.handle_out)
          $display("%0t: handle_out exp %0h got %0h", $time, want.handle_out,
                   rsp.data.handle_out);
        if (rsp.data.first_pos !== want.first_pos)
          $display("%0t: first_pos exp %0d got %0d", $time, want.first_pos,
                   rsp.data.first_pos);
        if (rsp.data.last_pos !== want.last_pos)
          $display("%0t: last_pos exp %0d got %0d", $time, want.last_pos,
                   rsp.data.last_pos);
        if (rsp.data.dated_count !== want.dated_count)
          $display("%0t: dated_count exp %0d got %0d", $time, want.dated_count,
                   rsp.data.dated_count);
        if (rsp.data.total_count !== want.total_count)
          $display("%0t: total_count exp %0d got %0d", $time, want.total_count,
                   rsp.data.total_count);
        if (rsp.data !== want) errors++;
      end
    end
  end

  // Random key; a narrow pool of dates so equal ranges and ties happen often.
  function automatic sdt_pkg::req_beat_t rand_cmd(logic [sdt_pkg::FUNC_W-1:0] f);
    sdt_pkg::req_beat_t c;
    c.func        = f;
    c.handle      = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    c.has_date    = 1'($urandom);
    case ($urandom_range(3))
      0: begin
        c.year        = 14'($urandom);
        c.day_of_year = 9'($urandom);
        c.time_of_day = {5'($urandom), 32'($urandom)};
      end
      default: begin
        c.year        = 14'(2000 + $urandom_range(2));
        c.day_of_year = 9'($urandom_range(1, 4));
        c.time_of_day = 37'($urandom_range(3));
      end
    endcase
    c.index = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(16));
    return c;
  endfunction

  // Directed: field extremes, every operation, each special case.
  task automatic test_directed();
    sdt_pkg::req_beat_t c;
    c = '0;
    c.func = sdt_pkg::FN_UNDATED_RANGE;           send_cmd(c); // empty undated range
    c.func = sdt_pkg::FN_DATE_RANGE;              send_cmd(c); // empty date range
    c.func = sdt_pkg::FN_READ_INDEX; c.index = 0; send_cmd(c); // bad index
    c.func = sdt_pkg::FN_REM_HANDLE;              send_cmd(c); // absent handle
    c = '0; c.func = sdt_pkg::FN_INSERT; c.has_date = 1'b1;
    c.year = 14'd9999; c.day_of_year = 9'd366; c.time_of_day = 37'd86399999999;
    c.handle = 16'hffff; send_cmd(c);
    c.year = 14'd1; c.day_of_year = 9'd1; c.time_of_day = '0; c.handle = 16'h0001;
    send_cmd(c);                        // goes ahead of the tail
    c.handle = 16'h0002; send_cmd(c);   // equal key, not the tail: goes first
    c.year = '1; c.day_of_year = '1; c.time_of_day = '1; c.handle = 16'h0003;
    send_cmd(c);                        // raw max key, appended
    c.handle = 16'h0004; send_cmd(c);   // ties the tail, appended
    c.has_date = 1'b0; c.handle = 16'h0000; send_cmd(c);
    c.handle = 16'h0002; send_cmd(c);
    c = '0; c.func = sdt_pkg::FN_DATE_RANGE; c.year = 14'd1; c.day_of_year = 9'd1;
    c.time_of_day = '1;
    send_cmd(c);
    c.func = sdt_pkg::FN_UNDATED_RANGE; send_cmd(c);
    c = '0; c.func = sdt_pkg::FN_READ_INDEX; c.index = 7'd4; send_cmd(c);
    c.index = 7'd3; send_cmd(c);
    c.index = 7'd7; send_cmd(c);        // just past total
    c.index = 7'h7f; send_cmd(c);
    c.func = sdt_pkg::FN_REM_HANDLE; c.handle = 16'h0002; send_cmd(c); // dated match first
    c.func = sdt_pkg::FN_REM_INDEX; c.index = 7'd3; send_cmd(c);
    c.index = 7'h7f; send_cmd(c);
    c.func = 3'd6; send_cmd(c);
    c.func = 3'd7; c.handle = '1; c.index = '1; send_cmd(c);
  endtask

  // Fill both lists past capacity, then remove at random indexes, to hit the full-list case.
  task automatic test_full_lists();
    sdt_pkg::req_beat_t c;
    for (int i = 0; i < NDATED + NUNDATED + 4; i++) begin
      c = rand_cmd(sdt_pkg::FN_INSERT);
      c.has_date = (i < NDATED + 2);
      send_cmd(c);
    end
    for (int i = 0; i < 8; i++) send_cmd(rand_cmd(sdt_pkg::FN_DATE_RANGE));
    for (int i = 0; i < NDATED + NUNDATED + 2; i++) begin
      c = rand_cmd(sdt_pkg::FN_REM_INDEX);
      c.index = 7'($urandom_range(NDATED + NUNDATED));
      send_cmd(c);
    end
  endtask

  // Random mix, biased to inserts so the lists grow to useful depth.
  task automatic test_random(int n);
    int pick;
    logic [sdt_pkg::FUNC_W-1:0] f;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 40)      f = sdt_pkg::FN_INSERT;
      else if (pick < 52) f = sdt_pkg::FN_REM_HANDLE;
      else if (pick < 62) f = sdt_pkg::FN_REM_INDEX;
      else if (pick < 76) f = sdt_pkg::FN_READ_INDEX;
      else if (pick < 82) f = sdt_pkg::FN_UNDATED_RANGE;
      else if (pick < 97) f = sdt_pkg::FN_DATE_RANGE;
      else                f = sdt_pkg::FUNC_W'($urandom_range(6, 7));
      send_cmd(rand_cmd(f));
    end
  endtask

  // Receiver holds off long enough that the block stalls its input.
  task automatic test_backpressure();
    req.valid <= 1'b0;
    @(negedge clk);
    hold_off_cycles = 300;
    test_random(20);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    errors = 0; n_beats_sent = 0; n_beats_checked = 0; n_ok = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
    rst       = 1'b1;
    req.valid = 1'b0;
    req.data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_full_lists();
    test_random(250);
    send_idle_pct = 71; test_random(250);
    send_idle_pct = 0; recv_stall_pct = 71; test_random(250);
    send_idle_pct = 21; recv_stall_pct = 21; test_random(250);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_backpressure();
    drain();

    $display("covered %0d commands, %0d responses checked, %0d with ok set",
             n_beats_sent, n_beats_checked, n_ok);
    if (errors == 0 && pending_rsp.size() == 0)
      $display("sorted_date_table_unit regression: pass");
    else
      $display("sorted_date_table_unit regression: fail");
    $finish;
  end

endmodule

[sim.f]
rtl/sdt_pkg.sv
rtl/sdt_req_if.sv
rtl/sdt_rsp_if.sv
rtl/sdt_cmp.sv
rtl/sorted_date_table_unit.sv
dv/tb_sorted_date_table_unit.sv
